>>> rtl/tea_pkg.sv
package tea_pkg;

  // Round constant of the key schedule.
  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  // Width of one block half.
  localparam int unsigned HALF_W = 32;

  // Operation codes carried with each block.
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  // Register map of the configuration port, by word index.
  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } tea_reg_t;

  // A block in flight through the round pipeline.
  typedef struct packed {
    logic              op;
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } tea_blk_t;

  // A finished result block.
  typedef struct packed {
    logic [HALF_W-1:0] left;
    logic [HALF_W-1:0] right;
  } tea_res_t;

  // The four key words as one bundle.
  typedef struct packed {
    logic [HALF_W-1:0] k0;
    logic [HALF_W-1:0] k1;
    logic [HALF_W-1:0] k2;
    logic [HALF_W-1:0] k3;
  } tea_key_t;

endpackage

>>> rtl/tea_round.sv
module tea_round import tea_pkg::*; #(
  parameter logic [31:0] SUM_ENC = 32'h9E37_79B9,
  parameter logic [31:0] SUM_DEC = 32'h9E37_79B9,
  parameter bit          ODD     = 1'b0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  tea_blk_t in_blk,
  input  tea_key_t key,
  output logic     out_valid,
  output tea_blk_t out_blk
);

  logic              upd_left;
  logic [HALF_W-1:0] x;
  logic [HALF_W-1:0] ka;
  logic [HALF_W-1:0] kb;
  logic [HALF_W-1:0] sum;
  logic [HALF_W-1:0] f;
  logic [HALF_W-1:0] target;
  logic [HALF_W-1:0] updated;
  tea_blk_t          blk_next;

  // One half-round. Enciphering updates the left half on even stages;
  // deciphering runs the same steps backward, so the roles swap.
  always_comb begin
    upd_left = (in_blk.op == OP_ENC) ^ ODD;
    sum      = (in_blk.op == OP_DEC) ? SUM_DEC : SUM_ENC;
    x        = upd_left ? in_blk.right : in_blk.left;
    ka       = upd_left ? key.k0 : key.k2;
    kb       = upd_left ? key.k1 : key.k3;
    f        = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    target   = upd_left ? in_blk.left : in_blk.right;
    updated  = (in_blk.op == OP_DEC) ? (target - f) : (target + f);
    blk_next = in_blk;
    if (upd_left) begin
      blk_next.left = updated;
    end else begin
      blk_next.right = updated;
    end
  end

  // Stage register; the whole pipeline holds while en is low.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_blk <= blk_next;
    end
  end

endmodule

>>> rtl/tea_out_buf.sv
module tea_out_buf import tea_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tea_res_t push_data,
  input  logic     ready,
  output logic     valid,
  output tea_res_t data,
  output logic     full
);

  logic [1:0] count;
  logic       pop;
  tea_res_t   head;
  tea_res_t   tail;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign pop   = valid && ready;
  assign data  = head;

  // Occupancy of the two-entry buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Head is the entry on the port; tail holds a second result during a stall.
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end else if (pop && !push) begin
      head <= tail;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        head <= push_data;
      end else begin
        head <= tail;
        tail <= push_data;
      end
    end
  end

endmodule

>>> rtl/tea_block_cipher.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   op, block_left, block_right
// out      output     out_valid/out_ready out_left, out_right
// cfg      APB        psel/penable/pready paddr, pwdata, prdata (key words)
//
// One block enters per cycle while in_ready is high; each of the 2*CYCLES
// pipeline stages runs one half-round. A result passes through every stage
// register and then into the output buffer, where it waits for the receiver.
// Reset clears the valid bits of every stage, the output buffer and the keys.
// A two-entry output buffer lets the pipeline keep moving while one result
// waits; the pipeline and the input hold only while a finished result sits in
// the last stage, the buffer is full and the receiver is not taking one.
module tea_block_cipher import tea_pkg::*; #(
  parameter int CYCLES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] block_left,
  input  logic [31:0] block_right,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_left,
  output logic [31:0] out_right,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int STAGES = 2 * CYCLES;

  tea_key_t key;
  tea_reg_t wr_reg;
  tea_reg_t rd_reg;
  logic     cfg_wr;
  logic     en;
  logic     buf_full;
  tea_res_t last_res;
  tea_res_t res;

  logic     stg_valid [0:STAGES];
  tea_blk_t stg_blk   [0:STAGES];

  // Configuration port: key words, writes on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_reg = tea_reg_t'(paddr[3:2]);
  assign rd_reg = tea_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_wr) begin
      unique case (wr_reg)
        REG_KEY0: key.k0 <= pwdata;
        REG_KEY1: key.k1 <= pwdata;
        REG_KEY2: key.k2 <= pwdata;
        REG_KEY3: key.k3 <= pwdata;
        default:  key    <= key;
      endcase
    end
  end

  always_comb begin
    unique case (rd_reg)
      REG_KEY0: prdata = key.k0;
      REG_KEY1: prdata = key.k1;
      REG_KEY2: prdata = key.k2;
      REG_KEY3: prdata = key.k3;
      default:  prdata = '0;
    endcase
  end

  // The pipeline advances unless a result would land on a full buffer.
  assign en       = !stg_valid[STAGES] || !buf_full || out_ready;
  assign in_ready = en;

  assign stg_valid[0] = in_valid;
  assign stg_blk[0]   = {op, block_left, block_right};

  // Half-round stages with their running sums worked out at elaboration.
  for (genvar j = 0; j < STAGES; j++) begin : g_round
    localparam logic [31:0] SUM_ENC = 32'(32'(j / 2 + 1) * DELTA);
    localparam logic [31:0] SUM_DEC = 32'(32'(CYCLES - j / 2) * DELTA);

    tea_round #(
      .SUM_ENC (SUM_ENC),
      .SUM_DEC (SUM_DEC),
      .ODD     (1'((j % 2) != 0))
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[j]),
      .in_blk    (stg_blk[j]),
      .key       (key),
      .out_valid (stg_valid[j+1]),
      .out_blk   (stg_blk[j+1])
    );
  end

  assign last_res = {stg_blk[STAGES].left, stg_blk[STAGES].right};

  // Output buffer decouples the pipeline from the result channel.
  tea_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (stg_valid[STAGES] && en),
    .push_data (last_res),
    .ready     (out_ready),
    .valid     (out_valid),
    .data      (res),
    .full      (buf_full)
  );

  assign out_left  = res.left;
  assign out_right = res.right;

endmodule
